@@ hdl/assert_macros.svh @@
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge outside reset.
`define TBR_ASSERT_ALWAYS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tbr assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define TBR_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbr assertion failed");

// Consequent holds in the cycle after the antecedent.
`define TBR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbr assertion failed");

`else

`define TBR_ASSERT_ALWAYS(name, cond)
`define TBR_ASSERT_IMPLIES(name, ante, cons)
`define TBR_ASSERT_NEXT(name, ante, cons)

`endif

`endif

@@ hdl/tbr_pkg.sv @@
// Shared constants, types and functions of the ternary block repacker.
package tbr_pkg;

    localparam int BYTE_W              = 8;
    localparam int CFG_W               = 15;
    localparam int BLOCK_BYTES         = 16;
    localparam int BLOCK_WEIGHTS       = 64;
    localparam int BLK_SHIFT           = $clog2(BLOCK_WEIGHTS);
    localparam int BYTE_IDX_W          = $clog2(BLOCK_BYTES);
    localparam int LANES               = 4;
    localparam int LANE_W              = $clog2(LANES);
    localparam int WORD_W              = LANES * BYTE_W;
    localparam int WORDS_PER_BLOCK     = BLOCK_BYTES / LANES;
    localparam int WORD_IDX_W          = $clog2(WORDS_PER_BLOCK);
    localparam int NUM_BANKS           = 2;
    localparam int BANK_W              = $clog2(NUM_BANKS);
    localparam int MEM_ADDR_W          = BANK_W + WORD_IDX_W;
    localparam int REM_W               = $clog2(BLOCK_WEIGHTS + 1);
    localparam int DEF_MAX_ROW_WEIGHTS = 16384;
    localparam logic [CFG_W-1:0] ROW_WEIGHTS_RESET = CFG_W'(64);

    localparam logic [1:0] RAW_NEG  = 2'd0;
    localparam logic [1:0] RAW_ZERO = 2'd1;
    localparam logic [1:0] W_ZERO   = 2'b00;
    localparam logic [1:0] W_POS    = 2'b01;
    localparam logic [1:0] W_NEG    = 2'b10;

    typedef struct packed {
        logic [BANK_W-1:0] bank;
        logic [REM_W-1:0]  rem;
        logic              last_block;
    } desc_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic logic [1:0] remap(input logic [1:0] raw);
        logic [1:0] code;
        unique case (raw)
            RAW_NEG:  code = W_NEG;
            RAW_ZERO: code = W_ZERO;
            default:  code = W_POS;
        endcase
        return code;
    endfunction

endpackage

@@ hdl/ternary_block_repacker_core.sv @@
// Top level of the ternary block repacker.
// Takes one grouped ternary byte per cycle and, after the 16th byte of a block,
// sends ceil(remaining/4) sequential bytes, one per cycle while out_stall is low;
// both sides sustain one byte per cycle. Two block buffers set that rate: the
// input stalls only while both hold blocks whose bytes are not yet all read out.
// Output passes the queue, buffer read and output registers. Writing row_weights
// restarts the row and drops a partly received block; do it only while idle.
`include "assert_macros.svh"

module ternary_block_repacker_core
    import tbr_pkg::*;
#(
    parameter int MAX_ROW_WEIGHTS = DEF_MAX_ROW_WEIGHTS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CFG_W-1:0]  cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] packed_in_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic              end_of_block,
    output logic              end_of_row
);

    logic                  q_push;
    logic                  q_pop;
    desc_t                 q_push_desc;
    desc_t                 q_head;
    q_stat_t               q_stat;
    logic                  wr_en;
    logic [MEM_ADDR_W-1:0] wr_addr;
    logic [LANE_W-1:0]     wr_lane;
    logic [BYTE_W-1:0]     wr_data;
    logic                  rd_en;
    logic [MEM_ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0]     rd_data;

    tbr_front #(
        .MAX_ROW_WEIGHTS (MAX_ROW_WEIGHTS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .packed_in_byte (packed_in_byte),
        .q_stat         (q_stat),
        .push           (q_push),
        .push_desc      (q_push_desc),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_lane        (wr_lane),
        .wr_data        (wr_data)
    );

    tbr_buf u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_lane (wr_lane),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    tbr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_push_desc),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    tbr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_stat       (q_stat),
        .pop          (q_pop),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .end_of_block (end_of_block),
        .end_of_row   (end_of_row)
    );

    `TBR_ASSERT_IMPLIES(a_no_overflow, q_push, !q_stat.full)
    `TBR_ASSERT_IMPLIES(a_no_underflow, q_pop, !q_stat.empty)
    `TBR_ASSERT_IMPLIES(a_row_ends_block, out_valid && end_of_row, end_of_block)
    `TBR_ASSERT_NEXT(a_pop_frees_bank, q_pop && !q_push, !q_stat.full)

endmodule

@@ hdl/tbr_buf.sv @@
// Ping-pong block memory: byte-lane writes, one registered word read.
module tbr_buf
    import tbr_pkg::*;
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [MEM_ADDR_W-1:0] wr_addr,
    input  logic [LANE_W-1:0]     wr_lane,
    input  logic [BYTE_W-1:0]     wr_data,
    input  logic                  rd_en,
    input  logic [MEM_ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0]     rd_data
);

    logic [WORD_W-1:0] mem_reg [NUM_BANKS*WORDS_PER_BLOCK];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr][BYTE_W*int'(wr_lane) +: BYTE_W] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/tbr_queue.sv @@
// Two-entry block descriptor queue between front and back.
module tbr_queue
    import tbr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  desc_t   push_desc,
    input  logic    pop,
    output desc_t   head,
    output q_stat_t stat
);

    localparam int CNT_W = $clog2(NUM_BANKS + 1);

    desc_t             slot_reg [NUM_BANKS];
    logic [BANK_W-1:0] wr_ptr_reg;
    logic [BANK_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + BANK_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + BANK_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.empty = (cnt_reg == '0);
    assign stat.full  = (cnt_reg == CNT_W'(NUM_BANKS));

endmodule

@@ hdl/tbr_front.sv @@
// Input side: byte capture into the block memory and row bookkeeping.
module tbr_front
    import tbr_pkg::*;
#(
    parameter int MAX_ROW_WEIGHTS = DEF_MAX_ROW_WEIGHTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     packed_in_byte,
    input  q_stat_t               q_stat,
    output logic                  push,
    output desc_t                 push_desc,
    output logic                  wr_en,
    output logic [MEM_ADDR_W-1:0] wr_addr,
    output logic [LANE_W-1:0]     wr_lane,
    output logic [BYTE_W-1:0]     wr_data
);

    localparam int ROW_W  = $clog2(MAX_ROW_WEIGHTS + 1);
    localparam int NBLK   = (MAX_ROW_WEIGHTS + BLOCK_WEIGHTS - 1) / BLOCK_WEIGHTS;
    localparam int BLK_W  = (NBLK > 1) ? $clog2(NBLK) : 1;
    localparam int W1     = (ROW_W > CFG_W) ? ROW_W : CFG_W;
    localparam int CALC_W = ((W1 > BLK_W + BLK_SHIFT) ? W1 : BLK_W + BLK_SHIFT) + 1;

    logic [CFG_W-1:0]      row_reg;
    logic [BYTE_IDX_W-1:0] byte_reg;
    logic [BLK_W-1:0]      block_reg;
    logic [BANK_W-1:0]     bank_reg;

    logic                  accept;
    logic                  block_done;
    logic [CALC_W-1:0]     eff;
    logic [CALC_W-1:0]     start;
    logic [CALC_W-1:0]     remain;
    logic                  last_block;

    assign in_stall   = q_stat.full;
    assign accept     = in_valid && !in_stall;
    assign block_done = accept && (byte_reg == BYTE_IDX_W'(BLOCK_BYTES - 1));

    always_comb
    begin
        if (row_reg == '0)
        begin
            eff = CALC_W'(1);
        end
        else if (CALC_W'(row_reg) > CALC_W'(MAX_ROW_WEIGHTS))
        begin
            eff = CALC_W'(MAX_ROW_WEIGHTS);
        end
        else
        begin
            eff = CALC_W'(row_reg);
        end
        start      = CALC_W'(block_reg) << BLK_SHIFT;
        remain     = eff - start;
        last_block = (remain <= CALC_W'(BLOCK_WEIGHTS));
    end

    assign push                 = block_done;
    assign push_desc.bank       = bank_reg;
    assign push_desc.rem        = last_block ? remain[REM_W-1:0] : REM_W'(BLOCK_WEIGHTS);
    assign push_desc.last_block = last_block;

    assign wr_en   = accept;
    assign wr_addr = {bank_reg, byte_reg[BYTE_IDX_W-1:LANE_W]};
    assign wr_lane = byte_reg[LANE_W-1:0];
    assign wr_data = packed_in_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= ROW_WEIGHTS_RESET;
            byte_reg  <= '0;
            block_reg <= '0;
            bank_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            row_reg   <= cfg_wr_data;
            byte_reg  <= '0;
            block_reg <= '0;
        end
        else if (accept)
        begin
            byte_reg <= byte_reg + BYTE_IDX_W'(1);
            if (block_done)
            begin
                bank_reg  <= bank_reg + BANK_W'(1);
                block_reg <= last_block ? '0 : block_reg + BLK_W'(1);
            end
        end
    end

endmodule

@@ hdl/tbr_back.sv @@
// Output side: reads buffered blocks word by word and emits sequential bytes.
module tbr_back
    import tbr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  desc_t                 head,
    input  q_stat_t               q_stat,
    output logic                  pop,
    output logic                  rd_en,
    output logic [MEM_ADDR_W-1:0] rd_addr,
    input  logic [WORD_W-1:0]     rd_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [BYTE_W-1:0]     out_byte,
    output logic                  end_of_block,
    output logic                  end_of_row
);

    localparam int GRP_W = BYTE_IDX_W - WORD_IDX_W;

    logic [BYTE_IDX_W-1:0] cnt_reg;
    logic                  s1_valid_reg;
    logic [GRP_W-1:0]      s1_grp_reg;
    logic                  s1_last_reg;
    logic                  s1_row_reg;
    logic [LANE_W-1:0]     s1_tail_reg;
    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic                  eob_reg;
    logic                  eor_reg;

    logic [REM_W-1:0]      rem_m1;
    logic                  is_last;
    logic                  out_ready;
    logic                  s1_adv;
    logic                  issue;
    logic [BYTE_W-1:0]     byte_next;

    assign rem_m1    = head.rem - REM_W'(1);
    assign is_last   = (cnt_reg == rem_m1[BYTE_IDX_W+LANE_W-1:LANE_W]);
    assign out_ready = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_ready;
    assign issue     = !q_stat.empty && (!s1_valid_reg || out_ready);
    assign pop       = issue && is_last;
    assign rd_en     = issue;
    assign rd_addr   = {head.bank, cnt_reg[WORD_IDX_W-1:0]};

    always_comb
    begin
        logic [1:0] raw;
        byte_next = '0;
        for (int w = 0; w < LANES; w++)
        begin
            raw = rd_data[BYTE_W*w + BYTE_W - 2 - 2*int'(s1_grp_reg) +: 2];
            if (!s1_last_reg || (LANE_W'(w) <= s1_tail_reg))
            begin
                byte_next[2*w +: 2] = remap(raw);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                cnt_reg <= is_last ? '0 : cnt_reg + BYTE_IDX_W'(1);
            end
            if (issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_grp_reg  <= cnt_reg[BYTE_IDX_W-1:WORD_IDX_W];
            s1_last_reg <= is_last;
            s1_row_reg  <= is_last && head.last_block;
            s1_tail_reg <= rem_m1[LANE_W-1:0];
        end
        if (s1_adv)
        begin
            out_byte_reg <= byte_next;
            eob_reg      <= s1_last_reg;
            eor_reg      <= s1_row_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign end_of_block = eob_reg;
    assign end_of_row   = eor_reg;

endmodule
